// ===== src/gmb_pkg.sv =====
// Shared types, constants and helpers for the glyph mask blitter.
package gmb_pkg;

    localparam int MAX_GLYPH_SIDE = 256;
    localparam int CNT_W          = $clog2(MAX_GLYPH_SIDE);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_GLYPH_SIDE - 1);

    localparam int ORIGIN_W = 11;
    localparam int SCREEN_W = 12;
    localparam int STRIDE_W = 14;
    localparam int COORD_W  = $clog2((2 ** ORIGIN_W) + MAX_GLYPH_SIDE - 1);
    localparam int PROD_W   = COORD_W + STRIDE_W;
    localparam int OFFS_W   = COORD_W + 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        PIX_1BPP  = 2'd0,
        PIX_8BPP  = 2'd1,
        PIX_16BPP = 2'd2,
        PIX_32BPP = 2'd3
    } pix_fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_BASE    = 3'd0,
        REG_SCREEN_WIDTH  = 3'd1,
        REG_SCREEN_HEIGHT = 3'd2,
        REG_LINE_STRIDE   = 3'd3,
        REG_PIXEL_FORMAT  = 3'd4,
        REG_PEN_COLOR     = 3'd5,
        REG_ORIGIN_COL    = 3'd6,
        REG_ORIGIN_ROW    = 3'd7
    } cfg_idx_t;

    localparam logic [3:0] BE_BYTE = 4'b0001;
    localparam logic [3:0] BE_HALF = 4'b0011;
    localparam logic [3:0] BE_WORD = 4'b1111;

    typedef struct packed {
        logic [31:0]         frame_base;
        logic [SCREEN_W-1:0] screen_width;
        logic [SCREEN_W-1:0] screen_height;
        logic [STRIDE_W-1:0] line_stride;
        pix_fmt_t            pixel_format;
        logic [31:0]         pen_color;
        logic [ORIGIN_W-1:0] origin_col;
        logic [ORIGIN_W-1:0] origin_row;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } pix_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic [15:0] pack_rgb565(input logic [31:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== src/gmb_front.sv =====
// Front end: glyph column/row tracking, edge clipping and write selection.
module gmb_front (
    input  logic          clk,
    input  logic          rst_n,
    input  gmb_pkg::cfg_t cfg,
    input  logic          in_accept,
    input  logic [7:0]    coverage,
    input  logic          row_end,
    input  logic          glyph_end,
    output logic          push,
    output gmb_pkg::pix_t pix
);
    import gmb_pkg::*;

    logic [CNT_W-1:0] glyph_col_reg, glyph_col_next;
    logic [CNT_W-1:0] glyph_row_reg, glyph_row_next;
    logic             row_clipped_reg, row_clipped_next;
    logic             in_frame;
    logic             clipped_now;

    assign pix.x = COORD_W'(cfg.origin_col) + COORD_W'(glyph_col_reg);
    assign pix.y = COORD_W'(cfg.origin_row) + COORD_W'(glyph_row_reg);

    assign in_frame    = (pix.x < COORD_W'(cfg.screen_width))
                      && (pix.y < COORD_W'(cfg.screen_height));
    assign clipped_now = row_clipped_reg || !in_frame;
    assign push        = in_accept && !clipped_now && (coverage != 8'd0);

    always_comb
    begin
        glyph_col_next   = glyph_col_reg;
        glyph_row_next   = glyph_row_reg;
        row_clipped_next = row_clipped_reg;
        if (in_accept)
        begin
            if (glyph_end)
            begin
                glyph_col_next   = '0;
                glyph_row_next   = '0;
                row_clipped_next = 1'b0;
            end
            else if (row_end)
            begin
                glyph_col_next   = '0;
                glyph_row_next   = bump(glyph_row_reg);
                row_clipped_next = 1'b0;
            end
            else
            begin
                glyph_col_next   = bump(glyph_col_reg);
                row_clipped_next = clipped_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_col_reg   <= '0;
            glyph_row_reg   <= '0;
            row_clipped_reg <= 1'b0;
        end
        else
        begin
            glyph_col_reg   <= glyph_col_next;
            glyph_row_reg   <= glyph_row_next;
            row_clipped_reg <= row_clipped_next;
        end
    end

    a_glyph_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && glyph_end |=>
            glyph_col_reg == '0 && glyph_row_reg == '0 && !row_clipped_reg)
        else $error("glyph end did not clear counters");

    a_clipped_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        row_clipped_reg |-> !push)
        else $error("write issued on a clipped row");

endmodule

// ===== src/gmb_fifo.sv =====
// Short pixel queue between the front end and the write back end.
module gmb_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gmb_pkg::pix_t       push_data,
    input  logic                pop,
    output gmb_pkg::pix_t       pop_data,
    output gmb_pkg::fifo_stat_t stat
);
    import gmb_pkg::*;

    pix_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign stat.full  = (count_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (FIFO_AW + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (FIFO_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        stat.full |-> !push || pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        stat.empty |-> !pop)
        else $error("pop from empty queue");

endmodule

// ===== src/gmb_back.sv =====
// Back end: address multiply-add, pixel packing and the output register.
module gmb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  gmb_pkg::cfg_t       cfg,
    input  logic                empty,
    input  gmb_pkg::pix_t       head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         write_address,
    output logic [31:0]         write_data,
    output logic [3:0]          byte_enables,
    output logic                or_into_byte
);
    import gmb_pkg::*;

    logic              a_valid_reg, a_valid_next;
    logic [PROD_W-1:0] a_prod_reg;
    logic [OFFS_W-1:0] a_offs_reg;
    logic [31:0]       a_data_reg;
    logic [3:0]        a_be_reg;
    logic              a_or_reg;

    logic              out_valid_reg, out_valid_next;
    logic [31:0]       addr_reg;
    logic [31:0]       data_reg;
    logic [3:0]        be_reg;
    logic              or_reg;

    logic              out_load;
    logic              a_load;
    logic [PROD_W-1:0] prod;
    logic [OFFS_W-1:0] offs;
    logic [31:0]       data;
    logic [3:0]        be;
    logic              orb;

    assign out_load = !out_valid_reg || !out_stall;
    assign a_load   = !a_valid_reg || out_load;
    assign pop      = !empty && a_load;

    assign prod = {STRIDE_W'(0), head.y} * {COORD_W'(0), cfg.line_stride};

    always_comb
    begin
        case (cfg.pixel_format)
            PIX_1BPP:
            begin
                offs = OFFS_W'(head.x >> 3);
                data = 32'(8'h80 >> head.x[2:0]);
                be   = BE_BYTE;
                orb  = 1'b1;
            end
            PIX_8BPP:
            begin
                offs = {2'b00, head.x};
                data = {24'd0, cfg.pen_color[7:0]};
                be   = BE_BYTE;
                orb  = 1'b0;
            end
            PIX_16BPP:
            begin
                offs = {1'b0, head.x, 1'b0};
                data = {16'd0, pack_rgb565(cfg.pen_color)};
                be   = BE_HALF;
                orb  = 1'b0;
            end
            default:
            begin
                offs = {head.x, 2'b00};
                data = cfg.pen_color;
                be   = BE_WORD;
                orb  = 1'b0;
            end
        endcase
    end

    assign a_valid_next   = a_load ? !empty : a_valid_reg;
    assign out_valid_next = out_load ? a_valid_reg : out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_prod_reg <= prod;
            a_offs_reg <= offs;
            a_data_reg <= data;
            a_be_reg   <= be;
            a_or_reg   <= orb;
        end
        if (out_load && a_valid_reg)
        begin
            addr_reg <= cfg.frame_base + 32'(a_prod_reg) + 32'(a_offs_reg);
            data_reg <= a_data_reg;
            be_reg   <= a_be_reg;
            or_reg   <= a_or_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_address = addr_reg;
    assign write_data    = data_reg;
    assign byte_enables  = be_reg;
    assign or_into_byte  = or_reg;

    a_or_byte_lane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && or_reg |-> be_reg == BE_BYTE)
        else $error("bit-mask write not on a single byte lane");

endmodule

// ===== src/glyph_mask_blitter_unit.sv =====
// Glyph mask blitter top level: configuration registers and the front/queue/back chain.
// Takes one coverage byte per clock while in_stall is low and gives at most one
// framebuffer write beat per byte; a write beat passes through a queue slot, the address
// multiply stage and the output register, and the sustained rate is one byte per cycle
// as long as out_stall stays low. The queue and the two back stages hold six pending
// beats; in a steady stream in_stall rises when the queue is full. Bytes that are clipped
// or have zero coverage give no beat. Configuration writes are meant for idle periods only.
module glyph_mask_blitter_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [gmb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         coverage,
    input  logic                               row_end,
    input  logic                               glyph_end,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [31:0]                        write_address,
    output logic [31:0]                        write_data,
    output logic [3:0]                         byte_enables,
    output logic                               or_into_byte
);
    import gmb_pkg::*;

    cfg_t       cfg_reg;
    logic       in_accept;
    logic       push;
    pix_t       push_pix;
    pix_t       head_pix;
    logic       pop;
    fifo_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_base    <= 32'd0;
            cfg_reg.screen_width  <= SCREEN_W'(640);
            cfg_reg.screen_height <= SCREEN_W'(480);
            cfg_reg.line_stride   <= STRIDE_W'(2560);
            cfg_reg.pixel_format  <= PIX_32BPP;
            cfg_reg.pen_color     <= 32'h00FF_FFFF;
            cfg_reg.origin_col    <= '0;
            cfg_reg.origin_row    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_FRAME_BASE:    cfg_reg.frame_base    <= cfg_data;
                REG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data[SCREEN_W-1:0];
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data[SCREEN_W-1:0];
                REG_LINE_STRIDE:   cfg_reg.line_stride   <= cfg_data[STRIDE_W-1:0];
                REG_PIXEL_FORMAT:  cfg_reg.pixel_format  <= pix_fmt_t'(cfg_data[1:0]);
                REG_PEN_COLOR:     cfg_reg.pen_color     <= cfg_data;
                REG_ORIGIN_COL:    cfg_reg.origin_col    <= cfg_data[ORIGIN_W-1:0];
                REG_ORIGIN_ROW:    cfg_reg.origin_row    <= cfg_data[ORIGIN_W-1:0];
                default:           cfg_reg.frame_base    <= cfg_reg.frame_base;
            endcase
        end
    end

    assign in_stall  = stat.full;
    assign in_accept = in_valid && !in_stall;

    gmb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_accept (in_accept),
        .coverage  (coverage),
        .row_end   (row_end),
        .glyph_end (glyph_end),
        .push      (push),
        .pix       (push_pix)
    );

    gmb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_pix),
        .pop       (pop),
        .pop_data  (head_pix),
        .stat      (stat)
    );

    gmb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .empty         (stat.empty),
        .head          (head_pix),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_address (write_address),
        .write_data    (write_data),
        .byte_enables  (byte_enables),
        .or_into_byte  (or_into_byte)
    );

endmodule

// ===== bench/tb_glyph_mask_blitter_unit.sv =====
// Testbench for glyph_mask_blitter_unit: streams glyph coverage bytes and checks every write beat.
`timescale 1ns / 100ps

module tb_glyph_mask_blitter_unit;
    import gmb_pkg::*;

    typedef struct packed {
        logic [7:0] cov;
        logic       re;
        logic       ge;
    } glyph_byte_t;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] data;
        logic [3:0]  lanes;
        logic        merge;
    } blit_write_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [7:0]           coverage;
    logic                 row_end;
    logic                 glyph_end;
    logic                 out_valid;
    logic                 out_stall;
    logic [31:0]          write_address;
    logic [31:0]          write_data;
    logic [3:0]           byte_enables;
    logic                 or_into_byte;

    glyph_mask_blitter_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .coverage      (coverage),
        .row_end       (row_end),
        .glyph_end     (glyph_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_address (write_address),
        .write_data    (write_data),
        .byte_enables  (byte_enables),
        .or_into_byte  (or_into_byte)
    );

    // register copies
    logic [31:0]         fb_base;
    logic [SCREEN_W-1:0] scr_w;
    logic [SCREEN_W-1:0] scr_h;
    logic [STRIDE_W-1:0] fb_stride;
    pix_fmt_t            fb_fmt;
    logic [31:0]         pen;
    logic [ORIGIN_W-1:0] org_col;
    logic [ORIGIN_W-1:0] org_row;

    // glyph walk state
    logic [7:0] col_cnt;
    logic [7:0] row_cnt;
    logic       row_clip;

    glyph_byte_t pending_bytes[$];
    blit_write_t expected_writes[$];
    glyph_byte_t next_byte;
    blit_write_t want;

    int  bytes_queued;
    int  bytes_accepted;
    int  writes_seen;
    int  reg_writes;
    int  failures;
    int  send_gap;
    int  stall_left;
    int  free_left;
    int  hold_left;
    bit  beat_taken;
    bit  idle_mode;
    bit  hold_req;
    bit  hold_done;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_cov();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return 8'h00;
        if (r < 30)
            return 8'hFF;
        if (r < 35)
            return 8'h01;
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic void note_failure(input string what);
        failures++;
        if (failures <= 10)
            $display("%s", what);
    endfunction

    function automatic void predict_blit(input logic [7:0] cov, input logic re, input logic ge);
        logic [11:0] px;
        logic [11:0] py;
        blit_write_t w;
        px = {1'b0, org_col} + {4'b0, col_cnt};
        py = {1'b0, org_row} + {4'b0, row_cnt};
        if (!row_clip && !(px < scr_w && py < scr_h))
            row_clip = 1'b1;
        if (!row_clip && cov != 8'h00)
        begin
            w.address = fb_base + 32'(py) * 32'(fb_stride);
            w.merge   = 1'b0;
            case (fb_fmt)
                PIX_1BPP:
                begin
                    w.address += 32'(px >> 3);
                    w.data    = 32'(8'h80 >> px[2:0]);
                    w.lanes   = BE_BYTE;
                    w.merge   = 1'b1;
                end
                PIX_8BPP:
                begin
                    w.address += 32'(px);
                    w.data    = {24'b0, pen[7:0]};
                    w.lanes   = BE_BYTE;
                end
                PIX_16BPP:
                begin
                    w.address += 32'(px) * 32'd2;
                    w.data    = {16'b0, pen[23:19], pen[15:10], pen[7:3]};
                    w.lanes   = BE_HALF;
                end
                default:
                begin
                    w.address += 32'(px) * 32'd4;
                    w.data    = pen;
                    w.lanes   = BE_WORD;
                end
            endcase
            expected_writes.push_back(w);
        end
        if (ge)
        begin
            col_cnt  = 8'h00;
            row_cnt  = 8'h00;
            row_clip = 1'b0;
        end
        else if (re)
        begin
            col_cnt  = 8'h00;
            row_clip = 1'b0;
            if (row_cnt != 8'hFF)
                row_cnt++;
        end
        else if (col_cnt != 8'hFF)
        begin
            col_cnt++;
        end
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_FRAME_BASE:    fb_base   = value;
            REG_SCREEN_WIDTH:  scr_w     = value[SCREEN_W-1:0];
            REG_SCREEN_HEIGHT: scr_h     = value[SCREEN_W-1:0];
            REG_LINE_STRIDE:   fb_stride = value[STRIDE_W-1:0];
            REG_PIXEL_FORMAT:  fb_fmt    = pix_fmt_t'(value[1:0]);
            REG_PEN_COLOR:     pen       = value;
            REG_ORIGIN_COL:    org_col   = value[ORIGIN_W-1:0];
            default:           org_row   = value[ORIGIN_W-1:0];
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic push_byte(input logic [7:0] cov, input logic re, input logic ge);
        glyph_byte_t b;
        b.cov = cov;
        b.re  = re;
        b.ge  = ge;
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_glyph(input int w, input int h);
        logic re;
        logic ge;
        for (int r = 0; r < h; r++)
        begin
            for (int c = 0; c < w; c++)
            begin
                re = (c == w - 1);
                ge = (r == h - 1) && (c == w - 1);
                if (ge)
                    re = 1'($urandom_range(0, 1));
                push_byte(pick_cov(), re, ge);
            end
        end
    endtask

    task automatic push_noise(input int n);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0,
                      $urandom_range(0, 11) == 0);
    endtask

    task automatic wait_idle();
        while (!(bytes_accepted == bytes_queued && expected_writes.size() == 0))
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic randomize_setup();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0:       v = 32'h0;
            1:       v = 32'hFFFF_FFFF - $urandom_range(0, 4096);
            default: v = $urandom;
        endcase
        write_reg(REG_FRAME_BASE, v);
        for (int k = 0; k < 2; k++)
        begin
            case ($urandom_range(0, 9))
                0:       v = 32'd2048;
                1:       v = $urandom_range(0, 4095);
                2:       v = 32'd1;
                default: v = $urandom_range(2, 48);
            endcase
            write_reg(k == 0 ? REG_SCREEN_WIDTH : REG_SCREEN_HEIGHT, v);
        end
        case ($urandom_range(0, 5))
            0:       v = 32'd0;
            1:       v = 32'd16383;
            default: v = $urandom_range(1, 8192);
        endcase
        write_reg(REG_LINE_STRIDE, v);
        write_reg(REG_PIXEL_FORMAT, $urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0:       v = 32'h0;
            1:       v = 32'hFFFF_FFFF;
            default: v = $urandom;
        endcase
        write_reg(REG_PEN_COLOR, v);
        for (int k = 0; k < 2; k++)
        begin
            case ($urandom_range(0, 7))
                0:       v = 32'd0;
                1:       v = 32'd2047;
                2:       v = $urandom_range(0, 2047);
                default: v = $urandom_range(0, 40);
            endcase
            write_reg(k == 0 ? REG_ORIGIN_COL : REG_ORIGIN_ROW, v);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // accept side of the input channel
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            predict_blit(coverage, row_end, glyph_end);
            bytes_accepted++;
            beat_taken = 1'b1;
        end
    end

    // input driver: hold a stalled beat, otherwise idle or advance
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !beat_taken))
        begin
            beat_taken = 1'b0;
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_bytes.size() > 0)
            begin
                next_byte = pending_bytes.pop_front();
                coverage  <= next_byte.cov;
                row_end   <= next_byte.re;
                glyph_end <= next_byte.ge;
                in_valid  <= 1'b1;
                send_gap  = idle_mode ? pick_gap() : 0;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output stall: long hold once on request, random runs in idle mode
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = 120;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (free_left > 0)
        begin
            out_stall <= 1'b0;
            free_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            free_left  = idle_mode ? pick_gap() : 64;
            stall_left = idle_mode ? pick_gap() : 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            writes_seen++;
            if (expected_writes.size() == 0)
            begin
                note_failure($sformatf("unexpected write beat: addr=%h data=%h be=%h or=%b",
                             write_address, write_data, byte_enables, or_into_byte));
            end
            else
            begin
                want = expected_writes.pop_front();
                if (write_address !== want.address || write_data !== want.data ||
                    byte_enables !== want.lanes || or_into_byte !== want.merge)
                    note_failure($sformatf(
                        {"write %0d mismatch: exp addr=%h data=%h be=%h or=%b, ",
                         "got addr=%h data=%h be=%h or=%b"},
                        writes_seen, want.address, want.data, want.lanes, want.merge,
                        write_address, write_data, byte_enables, or_into_byte));
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        coverage  = '0;
        row_end   = 1'b0;
        glyph_end = 1'b0;
        out_stall = 1'b0;
        fb_base   = 32'h0;
        scr_w     = 12'd640;
        scr_h     = 12'd480;
        fb_stride = 14'd2560;
        fb_fmt    = PIX_32BPP;
        pen       = 32'h00FF_FFFF;
        org_col   = '0;
        org_row   = '0;
        col_cnt   = '0;
        row_cnt   = '0;
        row_clip  = 1'b0;
        idle_mode = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // reset setup: 32 bpp, zero coverage skipped
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h01, 1'b1, 1'b0);
        push_byte(8'h80, 1'b0, 1'b1);
        wait_idle();

        // 1 bpp across a byte boundary, right and bottom clipping, address wrap
        write_reg(REG_FRAME_BASE, 32'hFFFF_FFFF);
        write_reg(REG_SCREEN_WIDTH, 32'd10);
        write_reg(REG_SCREEN_HEIGHT, 32'd2);
        write_reg(REG_LINE_STRIDE, 32'd16383);
        write_reg(REG_PIXEL_FORMAT, PIX_1BPP);
        write_reg(REG_PEN_COLOR, 32'h0);
        write_reg(REG_ORIGIN_COL, 32'd6);
        write_reg(REG_ORIGIN_ROW, 32'd1);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h7F, 1'b0, 1'b0);
        push_byte(8'h10, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b1);
        wait_idle();

        // 8 bpp, then a zero-width screen
        write_reg(REG_PIXEL_FORMAT, PIX_8BPP);
        write_reg(REG_PEN_COLOR, 32'hFFFF_FFFF);
        write_reg(REG_SCREEN_WIDTH, 32'd1);
        write_reg(REG_ORIGIN_COL, 32'd0);
        write_reg(REG_ORIGIN_ROW, 32'd0);
        push_byte(8'hAA, 1'b0, 1'b0);
        push_byte(8'hAA, 1'b1, 1'b0);
        wait_idle();
        write_reg(REG_SCREEN_WIDTH, 32'd0);
        push_byte(8'hFF, 1'b0, 1'b1);
        wait_idle();

        // 16 bpp at the far corner of a 2048 by 2048 screen
        write_reg(REG_PIXEL_FORMAT, PIX_16BPP);
        write_reg(REG_PEN_COLOR, 32'h12F8_5C3B);
        write_reg(REG_SCREEN_WIDTH, 32'd2048);
        write_reg(REG_SCREEN_HEIGHT, 32'd2048);
        write_reg(REG_LINE_STRIDE, 32'd1);
        write_reg(REG_FRAME_BASE, 32'h0);
        write_reg(REG_ORIGIN_COL, 32'd2047);
        write_reg(REG_ORIGIN_ROW, 32'd2047);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'h02, 1'b0, 1'b1);
        wait_idle();

        // back-pressure: receiver holds while the sender keeps offering
        write_reg(REG_ORIGIN_COL, 32'd0);
        write_reg(REG_ORIGIN_ROW, 32'd0);
        write_reg(REG_PIXEL_FORMAT, PIX_32BPP);
        hold_req = 1'b1;
        for (int g = 0; g < 6; g++)
            push_glyph(8, 1 + g % 2);
        wait_idle();

        // counter saturation in both directions
        write_reg(REG_ORIGIN_COL, 32'd1790);
        write_reg(REG_ORIGIN_ROW, 32'd1790);
        write_reg(REG_PIXEL_FORMAT, $urandom_range(0, 3));
        idle_mode = 1'b1;
        push_glyph(262, 1);
        push_glyph(1, 262);
        wait_idle();

        while (bytes_queued < 650)
        begin
            randomize_setup();
            idle_mode = $urandom_range(0, 3) != 0;
            for (int n = 0; n < 60; )
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    push_noise($urandom_range(5, 15));
                    n += 10;
                end
                else if ($urandom_range(0, 19) == 0)
                begin
                    push_glyph($urandom_range(1, 30), $urandom_range(1, 3));
                    n += 20;
                end
                else
                begin
                    push_glyph($urandom_range(1, 10), $urandom_range(1, 6));
                    n += 15;
                end
            end
            wait_idle();
        end

        failures += expected_writes.size();
        $display("Accepted %0d glyph bytes and checked %0d write beats (%0d left over).",
                 bytes_accepted, writes_seen, expected_writes.size());
        $display("Used %0d register writes over all pixel formats, clipping and saturation.",
                 reg_writes);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
